// ----- hdl/nscc_pkg.sv -----
`timescale 1ns / 1ps

package nscc_pkg;

  // Field widths of the item channels
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned LEN_W  = 7;
  localparam int unsigned SUM_W  = 8;

  // Message length bound; a message is cut off at this length less one byte, CR LF counted
  localparam int unsigned MAX_LEN_DEFAULT = 128;

  // Largest reportable length
  localparam int unsigned LEN_MAX = 127;

  // Framing characters
  localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
  localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;
  localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;

  // Input item kinds
  localparam logic MODE_BYTE    = 1'b0;
  localparam logic MODE_TIMEOUT = 1'b1;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_BAD     = 2'd1,
    ST_LONG    = 2'd2,
    ST_TIMEOUT = 2'd3
  } status_t;

  // Framing phase
  typedef enum logic [2:0] {
    PH_FIRST = 3'b001,
    PH_BODY  = 3'b010,
    PH_HEX   = 3'b100
  } phase_t;

endpackage

// ----- hdl/nscc_if.sv -----
`timescale 1ns / 1ps

// Received byte or timeout event
interface nscc_in_if;
  logic                           valid;
  logic                           ready;
  logic                           mode;
  logic [nscc_pkg::BYTE_W-1:0]    data_byte;

  modport source (output valid, output mode, output data_byte, input ready);
  modport sink   (input valid, input mode, input data_byte, output ready);
endinterface

// Message check result
interface nscc_out_if;
  logic                           valid;
  logic                           ready;
  logic [nscc_pkg::STAT_W-1:0]    status;
  logic [nscc_pkg::LEN_W-1:0]     msg_length;
  logic [nscc_pkg::SUM_W-1:0]     computed_sum;
  logic [nscc_pkg::SUM_W-1:0]     received_sum;

  modport source (output valid, output status, output msg_length, output computed_sum,
                  output received_sum, input ready);
  modport sink   (input valid, input status, input msg_length, input computed_sum,
                  input received_sum, output ready);
endinterface

// ----- hdl/nmea_sentence_checksum_checker_top.sv -----
`timescale 1ns / 1ps

// NMEA sentence checksum checker. Each input item is either a received byte or a
// receive timeout event. Bytes are framed into messages ending at CR LF; the first
// byte must be '$', the bytes up to the first '*' are XORed, and the hex digits after
// the '*' form the received checksum (low 8 bits). One result item is produced at
// CR LF (ok or bad), after MAX_LEN-1 bytes without CR LF (too long), or on a timeout,
// and the framer then restarts. The framing state updates at the accepting edge and the
// result lands on that same edge in the output register (skid if stalled), so one item
// is taken per clock while the skid is empty. A two-entry output stage (output register
// plus skid register) keeps input ready registered and lets items flow while a result
// waits to be taken. Reset is synchronous and active low; no clearing pass is needed.
module nmea_sentence_checksum_checker_top #(
  parameter int unsigned MAX_LEN = nscc_pkg::MAX_LEN_DEFAULT
) (
  input  logic         clk,
  input  logic         rst_n,
  nscc_in_if.sink      in_ch,
  nscc_out_if.source   out_ch
);

  localparam int unsigned CNT_W = $clog2(MAX_LEN);
  localparam int unsigned EXT_W = (CNT_W > nscc_pkg::LEN_W) ? CNT_W : nscc_pkg::LEN_W;
  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_LEN - 1);
  localparam logic [EXT_W-1:0] LEN_SAT   = EXT_W'(nscc_pkg::LEN_MAX);

  typedef struct packed {
    nscc_pkg::status_t               status;
    logic [nscc_pkg::LEN_W-1:0]      msg_length;
    logic [nscc_pkg::SUM_W-1:0]      computed_sum;
    logic [nscc_pkg::SUM_W-1:0]      received_sum;
  } result_t;

  // Hex digit decode: bit 4 flags a valid digit, bits 3:0 hold its value
  function automatic logic [4:0] hex_decode(input logic [nscc_pkg::BYTE_W-1:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end
    return r;
  endfunction

  // Framing state
  nscc_pkg::phase_t              phase_r, phase_nxt;
  logic                          dollar_ok_r, dollar_ok_nxt;
  logic [nscc_pkg::SUM_W-1:0]    xor_r, xor_nxt;
  logic [nscc_pkg::SUM_W-1:0]    hex_r, hex_nxt;
  logic                          hex_stop_r, hex_stop_nxt;
  logic [CNT_W-1:0]              count_r, count_nxt;
  logic                          prev_cr_r, prev_cr_nxt;

  // Output stage
  logic                          out_valid_r;
  result_t                       out_data_r;
  logic                          skid_valid_r;
  result_t                       skid_data_r;

  logic                          accept;
  logic                          is_byte;
  logic [nscc_pkg::BYTE_W-1:0]   c;
  logic [4:0]                    hex_dec;
  logic                          msg_end;
  logic                          too_long;
  logic                          res_valid;
  logic                          restart;
  logic                          star_seen;
  logic                          sums_match;
  logic [EXT_W-1:0]              count_ext;
  result_t                       res;

  assign in_ch.ready = !skid_valid_r;
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_byte     = (in_ch.mode == nscc_pkg::MODE_BYTE);
  assign c           = in_ch.data_byte;
  assign hex_dec     = hex_decode(c);

  // Advance the framing state for a received byte; a timeout leaves it as is
  always_comb begin
    phase_nxt     = phase_r;
    dollar_ok_nxt = dollar_ok_r;
    xor_nxt       = xor_r;
    hex_nxt       = hex_r;
    hex_stop_nxt  = hex_stop_r;
    count_nxt     = count_r;
    prev_cr_nxt   = prev_cr_r;
    if (is_byte) begin
      unique case (phase_r)
        nscc_pkg::PH_FIRST: begin
          dollar_ok_nxt = (c == nscc_pkg::CH_DOLLAR);
          phase_nxt     = nscc_pkg::PH_BODY;
        end
        nscc_pkg::PH_BODY: begin
          if (c == nscc_pkg::CH_STAR) begin
            phase_nxt = nscc_pkg::PH_HEX;
          end else begin
            xor_nxt = xor_r ^ c;
          end
        end
        nscc_pkg::PH_HEX: begin
          if (!hex_stop_r) begin
            if (hex_dec[4]) begin
              hex_nxt = {hex_r[3:0], hex_dec[3:0]};
            end else begin
              hex_stop_nxt = 1'b1;
            end
          end
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
      count_nxt   = count_r + CNT_W'(1);
      prev_cr_nxt = (c == nscc_pkg::CH_CR);
    end
  end

  // Decide whether this item closes the message
  assign msg_end   = is_byte && (count_r != '0) && prev_cr_r && (c == nscc_pkg::CH_LF);
  assign too_long  = is_byte && !msg_end && (count_nxt >= CNT_LIMIT);
  assign restart   = !is_byte || msg_end || too_long;
  assign res_valid = accept && restart;

  // Build the result from the updated state
  assign star_seen  = (phase_nxt == nscc_pkg::PH_HEX);
  assign sums_match = (xor_nxt == hex_nxt);
  assign count_ext  = EXT_W'(count_nxt);

  always_comb begin
    priority if (!is_byte) begin
      res.status = nscc_pkg::ST_TIMEOUT;
    end else if (msg_end) begin
      res.status = (dollar_ok_nxt && star_seen && sums_match) ? nscc_pkg::ST_OK
                                                              : nscc_pkg::ST_BAD;
    end else begin
      res.status = nscc_pkg::ST_LONG;
    end
    res.msg_length   = (count_ext > LEN_SAT) ? nscc_pkg::LEN_W'(nscc_pkg::LEN_MAX)
                                             : nscc_pkg::LEN_W'(count_ext);
    res.computed_sum = star_seen ? xor_nxt : '0;
    res.received_sum = star_seen ? hex_nxt : '0;
  end

  // Update framing state on each accepted item; restart after a result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= nscc_pkg::PH_FIRST;
      dollar_ok_r <= 1'b0;
      xor_r       <= '0;
      hex_r       <= '0;
      hex_stop_r  <= 1'b0;
      count_r     <= '0;
      prev_cr_r   <= 1'b0;
    end else if (accept) begin
      if (restart) begin
        phase_r     <= nscc_pkg::PH_FIRST;
        dollar_ok_r <= 1'b0;
        xor_r       <= '0;
        hex_r       <= '0;
        hex_stop_r  <= 1'b0;
        count_r     <= '0;
        prev_cr_r   <= 1'b0;
      end else begin
        phase_r     <= phase_nxt;
        dollar_ok_r <= dollar_ok_nxt;
        xor_r       <= xor_nxt;
        hex_r       <= hex_nxt;
        hex_stop_r  <= hex_stop_nxt;
        count_r     <= count_nxt;
        prev_cr_r   <= prev_cr_nxt;
      end
    end
  end

  // Output register with skid: drain the skid first, park a result when stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ch.ready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ch.ready) begin
      out_data_r <= skid_valid_r ? skid_data_r : res;
    end
    if (out_valid_r && !out_ch.ready && res_valid) begin
      skid_data_r <= res;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_data_r.status;
  assign out_ch.msg_length   = out_data_r.msg_length;
  assign out_ch.computed_sum = out_data_r.computed_sum;
  assign out_ch.received_sum = out_data_r.received_sum;

  // A parked result always sits behind a held one
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register holds an item while the output register is empty");

  // Waiting for the first byte means nothing has been counted
  a_first_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == nscc_pkg::PH_FIRST) |-> (count_r == '0 && !prev_cr_r))
    else $error("framer expects a first byte but holds a partial message");

  // An ok result carries matching checksums
  a_ok_match: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.status == nscc_pkg::ST_OK) |->
      (out_data_r.computed_sum == out_data_r.received_sum))
    else $error("ok status with differing checksums");

  // A result follows every accepted timeout event
  a_timeout_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ch.mode == nscc_pkg::MODE_TIMEOUT) |=> out_valid_r)
    else $error("timeout item produced no result");

endmodule

// ----- verif/nscc_report_monitor.sv -----
`timescale 1ns / 1ps

// Watch both channels, frame every accepted item and check each report against
// the sentence state kept here.
module nscc_report_monitor #(
  parameter int unsigned MAX_LEN = nscc_pkg::MAX_LEN_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic                         in_mode,
  input  logic [nscc_pkg::BYTE_W-1:0]  in_byte,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic [nscc_pkg::STAT_W-1:0]  out_status,
  input  logic [nscc_pkg::LEN_W-1:0]   out_length,
  input  logic [nscc_pkg::SUM_W-1:0]   out_calc,
  input  logic [nscc_pkg::SUM_W-1:0]   out_rcvd,
  output int unsigned                  mismatch_count,
  output int unsigned                  reports_waiting
);
  import nscc_pkg::*;

  typedef struct packed {
    status_t            status;
    logic [LEN_W-1:0]   length;
    logic [SUM_W-1:0]   calc;
    logic [SUM_W-1:0]   rcvd;
  } sentence_report_t;

  // Framing state of the sentence in progress
  phase_t            frame_phase;
  logic              dollar_seen;
  logic [SUM_W-1:0]  xor_sum;
  logic [SUM_W-1:0]  hex_sum;
  logic              hex_closed;
  int unsigned       bytes_taken;
  logic              last_was_cr;

  sentence_report_t  expected_reports[$];
  sentence_report_t  want;

  initial begin
    mismatch_count  = 0;
    reports_waiting = 0;
  end

  // Value of a hex digit character, or -1 for anything else
  function automatic int hex_nibble(input logic [BYTE_W-1:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    return -1;
  endfunction

  // Sums are only reported once a star has been seen
  function automatic sentence_report_t build_report(input status_t st);
    sentence_report_t r;
    r.status = st;
    r.length = (bytes_taken > LEN_MAX) ? LEN_W'(LEN_MAX) : LEN_W'(bytes_taken);
    r.calc   = (frame_phase == PH_HEX) ? xor_sum : '0;
    r.rcvd   = (frame_phase == PH_HEX) ? hex_sum : '0;
    return r;
  endfunction

  task automatic restart_frame();
    frame_phase = PH_FIRST;
    dollar_seen = 1'b0;
    xor_sum     = '0;
    hex_sum     = '0;
    hex_closed  = 1'b0;
    bytes_taken = 0;
    last_was_cr = 1'b0;
  endtask

  // Advance the framer by one item and queue the report it causes, if any
  task automatic take_item(input logic mode, input logic [BYTE_W-1:0] c);
    int   digit;
    logic at_end;
    logic ok;
    if (mode == MODE_TIMEOUT) begin
      expected_reports.push_back(build_report(ST_TIMEOUT));
      restart_frame();
    end else begin
      case (frame_phase)
        PH_FIRST: begin
          dollar_seen = (c == CH_DOLLAR);
          frame_phase = PH_BODY;
        end
        PH_BODY: begin
          if (c == CH_STAR) frame_phase = PH_HEX;
          else xor_sum = xor_sum ^ c;
        end
        default: begin
          if (!hex_closed) begin
            digit = hex_nibble(c);
            if (digit >= 0) hex_sum = {hex_sum[3:0], 4'(digit)};
            else hex_closed = 1'b1;
          end
        end
      endcase

      at_end      = (bytes_taken >= 1) && last_was_cr && (c == CH_LF);
      bytes_taken = bytes_taken + 1;
      last_was_cr = (c == CH_CR);

      if (at_end) begin
        ok = dollar_seen && (frame_phase == PH_HEX) && (xor_sum == hex_sum);
        expected_reports.push_back(build_report(ok ? ST_OK : ST_BAD));
        restart_frame();
      end else if (bytes_taken >= MAX_LEN - 1) begin
        expected_reports.push_back(build_report(ST_LONG));
        restart_frame();
      end
    end
  endtask

  // Check outgoing reports before taking the new item: a report leaving now
  // can never stem from the item accepted on the same edge
  always @(posedge clk) begin
    if (!rst_n) begin
      restart_frame();
      expected_reports.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_reports.size() == 0) begin
          mismatch_count = mismatch_count + 1;
          if (mismatch_count <= 10)
            $display("%0t: unexpected report status %0d len %0d calc %02h rcvd %02h",
                     $realtime, out_status, out_length, out_calc, out_rcvd);
        end else begin
          want = expected_reports.pop_front();
          if (want.status != out_status || want.length != out_length ||
              want.calc != out_calc || want.rcvd != out_rcvd) begin
            mismatch_count = mismatch_count + 1;
            if (mismatch_count <= 10)
              $display({"%0t: report mismatch: expected status %0d len %0d calc %02h",
                        " rcvd %02h, got status %0d len %0d calc %02h rcvd %02h"},
                       $realtime, want.status, want.length, want.calc, want.rcvd,
                       out_status, out_length, out_calc, out_rcvd);
          end
        end
      end
      if (in_valid && in_ready) take_item(in_mode, in_byte);
    end
    reports_waiting = expected_reports.size();
  end

endmodule

// ----- verif/nmea_sentence_checksum_checker_top_tb.sv -----
`timescale 1ns / 1ps

module nmea_sentence_checksum_checker_top_tb;
  import nscc_pkg::*;

  localparam int unsigned ITEM_TARGET  = 1300;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 20;

  logic clk;
  logic rst_n;

  nscc_in_if  in_ch ();
  nscc_out_if out_ch ();

  int unsigned mismatch_count;
  int unsigned reports_waiting;
  int unsigned items_sent;
  int unsigned burst_left;
  int unsigned holds_asked;
  int unsigned holds_done;

  nmea_sentence_checksum_checker_top #(
    .MAX_LEN (MAX_LEN_DEFAULT)
  ) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  nscc_report_monitor #(
    .MAX_LEN (MAX_LEN_DEFAULT)
  ) u_monitor (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .in_mode         (in_ch.mode),
    .in_byte         (in_ch.data_byte),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_status      (out_ch.status),
    .out_length      (out_ch.msg_length),
    .out_calc        (out_ch.computed_sum),
    .out_rcvd        (out_ch.received_sum),
    .mismatch_count  (mismatch_count),
    .reports_waiting (reports_waiting)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Abandon a hung run
  initial begin
    #1_000_000;
    $display("FAIL nmea_sentence_checksum_checker_top");
    $finish;
  end

  // Offer one item, in bursts with random gaps, and hold it until taken
  task automatic send_item(input logic mode, input logic [BYTE_W-1:0] c);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 20);
    end
    burst_left = burst_left - 1;
    in_ch.valid     <= 1'b1;
    in_ch.mode      <= mode;
    in_ch.data_byte <= c;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    items_sent = items_sent + 1;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(MODE_BYTE, s[i]);
  endtask

  task automatic send_crlf();
    send_item(MODE_BYTE, CH_CR);
    send_item(MODE_BYTE, CH_LF);
  endtask

  // Any byte but the star and CR, so it cannot close a field or the sentence
  function automatic logic [BYTE_W-1:0] pick_plain_byte();
    logic [BYTE_W-1:0] c;
    do c = BYTE_W'($urandom); while (c == CH_STAR || c == CH_CR);
    return c;
  endfunction

  function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] n, input bit lower);
    if (n < 10) return BYTE_W'("0" + n);
    return lower ? BYTE_W'("a" + n - 10) : BYTE_W'("A" + n - 10);
  endfunction

  // Sentence with random body, mostly well formed and with a correct checksum
  task automatic send_sentence();
    int unsigned       body_len;
    int unsigned       digits;
    logic [BYTE_W-1:0] c;
    logic [SUM_W-1:0]  sum;
    logic [SUM_W-1:0]  claimed;
    logic [3:0]        nib;
    body_len = $urandom_range(0, 12);
    sum      = '0;
    send_item(MODE_BYTE, ($urandom_range(0, 19) == 0) ? pick_plain_byte() : CH_DOLLAR);
    for (int i = 0; i < body_len; i++) begin
      c   = pick_plain_byte();
      sum = sum ^ c;
      send_item(MODE_BYTE, c);
    end
    send_item(MODE_BYTE, CH_STAR);
    claimed = ($urandom_range(0, 6) == 0) ? SUM_W'($urandom) : sum;
    case ($urandom_range(0, 9))
      0: digits = 0;
      1: digits = 1;
      2: digits = 3;
      3: digits = 4;
      default: digits = 2;
    endcase
    // Leading extra digits fall off the top of the 8-bit value
    for (int i = digits; i > 0; i--) begin
      if (i > 2) nib = 4'($urandom);
      else if (i == 2) nib = claimed[7:4];
      else nib = claimed[3:0];
      send_item(MODE_BYTE, hex_char(nib, 1'($urandom_range(0, 1))));
    end
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) send_item(MODE_BYTE, pick_plain_byte());
    send_crlf();
  endtask

  task automatic send_overlong();
    send_item(MODE_BYTE, CH_DOLLAR);
    repeat (MAX_LEN_DEFAULT - 2) send_item(MODE_BYTE, pick_plain_byte());
  endtask

  // Stimulus
  initial begin
    int unsigned kind;
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.mode      <= MODE_BYTE;
    in_ch.data_byte <= '0;
    items_sent  = 0;
    burst_left  = 0;
    holds_asked = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Timeout with nothing taken yet
    send_item(MODE_TIMEOUT, 8'hFF);
    // Correct sentence
    send_text("$A*41");
    send_crlf();
    // Star with no hex digits
    send_text("$*");
    send_crlf();
    // Star as first byte, no star afterwards
    send_text("*A");
    send_crlf();
    // Zero and all-ones bytes, lower-case digits
    send_item(MODE_BYTE, CH_DOLLAR);
    send_item(MODE_BYTE, 8'h00);
    send_item(MODE_BYTE, 8'hFF);
    send_text("*ff");
    send_crlf();
    // Hex field cut short by a non-hex byte
    send_text("$A*4g");
    send_crlf();
    // Timeout part way through
    send_text("$B");
    send_item(MODE_TIMEOUT, 8'h00);
    // No CR LF before the length limit
    send_overlong();

    // Random part; the first long receiver hold-off starts here
    holds_asked = holds_asked + 1;
    while (items_sent < ITEM_TARGET) begin
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
        send_sentence();
      end else if (kind < 75) begin
        repeat ($urandom_range(1, 20)) send_item(MODE_BYTE, BYTE_W'($urandom));
        if ($urandom_range(0, 9) < 7) send_crlf();
      end else if (kind < 85) begin
        send_item(MODE_BYTE, CH_DOLLAR);
        repeat ($urandom_range(0, 10)) send_item(MODE_BYTE, BYTE_W'($urandom));
        send_item(MODE_TIMEOUT, BYTE_W'($urandom));
      end else if (kind < 95) begin
        // Stray line endings
        if ($urandom_range(0, 1) == 0) send_item(MODE_BYTE, CH_CR);
        else send_item(MODE_BYTE, CH_LF);
        send_crlf();
      end else if (kind < 97) begin
        send_overlong();
      end else if (holds_asked < 3) begin
        holds_asked = holds_asked + 1;
      end else begin
        send_item(MODE_TIMEOUT, BYTE_W'($urandom));
      end
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait (reports_waiting == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && reports_waiting == 0)
      $display("PASS nmea_sentence_checksum_checker_top");
    else
      $display("FAIL nmea_sentence_checksum_checker_top");
    $finish;
  end

  // Receiver: stretches of full rate, random stalls and long hold-offs on request
  initial begin
    int unsigned span;
    out_ch.ready <= 1'b0;
    holds_done = 0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (holds_done != holds_asked) begin
        holds_done   = holds_done + 1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        span = $urandom_range(5, 40);
        case ($urandom_range(0, 3))
          0: repeat (span) begin
            out_ch.ready <= 1'b1;
            @(posedge clk);
          end
          1: repeat (span) begin
            out_ch.ready <= 1'($urandom_range(0, 1));
            @(posedge clk);
          end
          2: repeat (span) begin
            out_ch.ready <= ($urandom_range(0, 3) == 0);
            @(posedge clk);
          end
          default: begin
            out_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
          end
        endcase
      end
    end
  end

endmodule
